FILE: rtl/pmi_pkg.sv
// ----------------------------------------------------------------------------
// pmi_pkg: shared types and constants for the polyphase MAC interpolator
// Holds the fixed-point formats, derived widths and interpolation mode codes.
// ----------------------------------------------------------------------------
package pmi_pkg;

  // Sample, tap and weight width (signed Q1.FRAC) and accumulator width.
  localparam int SAMPLE_BITS = 16;
  localparam int ACC_BITS    = 48;

  // Derived formats.
  localparam int FRAC   = SAMPLE_BITS - 1;
  localparam int PROD_W = 2 * SAMPLE_BITS;
  localparam int DIFF_W = ACC_BITS + 1;
  localparam int TERM_W = ACC_BITS + SAMPLE_BITS + 1;
  localparam int SUM_W  = TERM_W + 3;
  localparam int SHIFT  = 2 * FRAC;

  // Register interface.
  localparam int ADDR_W   = 3;
  localparam int DATA_W   = 32;
  localparam int REG_IDX_W = ADDR_W - 2;
  localparam logic [REG_IDX_W-1:0] REG_INTERP_MODE = REG_IDX_W'(0);

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic signed [PROD_W-1:0]      prod_t;
  typedef logic signed [ACC_BITS-1:0]    acc_t;
  typedef logic signed [DIFF_W-1:0]      diff_t;
  typedef logic signed [TERM_W-1:0]      term_t;
  typedef logic signed [SUM_W-1:0]       sum_t;
  typedef logic [1:0]                    mode_t;

  // Interpolation modes; the unused code behaves as full.
  localparam mode_t MODE_FULL   = 2'd0;
  localparam mode_t MODE_LINEAR = 2'd1;
  localparam mode_t MODE_CUBIC  = 2'd2;

  // Rounding offset in the combined Q.3F format; saturation bounds in the Q1.FRAC sample format.
  localparam sum_t ROUND_OFS = sum_t'(1) <<< (SHIFT - 1);
  localparam sum_t SAT_MAX   = (sum_t'(1) <<< FRAC) - sum_t'(1);
  localparam sum_t SAT_MIN   = -(sum_t'(1) <<< FRAC);

endpackage

FILE: rtl/polyphase_mac_interpolated.sv
// ----------------------------------------------------------------------------
// polyphase_mac_interpolated: polyphase resampler output point
// Four-row multiply-accumulate with full, linear or cubic phase interpolation.
// ----------------------------------------------------------------------------
// The block takes one input transaction per clock cycle. Each transaction
// multiplies the sample by its four taps and adds the products into four
// wrapping accumulators; a transaction with last set closes the window, and
// its result reaches the output through the registers in turn: the tap
// products, the accumulator update, the weight products and the final sum
// with rounding and saturation. The four-stage pipeline moves as a whole:
// while a result is waiting and stalled, the whole pipeline holds and
// in_stall is raised; otherwise a new transaction is taken every cycle.
// The user must write interp_mode through the register port only while no
// transaction is in flight; the block itself does not enforce this.
module polyphase_mac_interpolated (
  input  logic                          clk,
  input  logic                          rst,
  // Register port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [pmi_pkg::ADDR_W-1:0]    paddr,
  input  logic [pmi_pkg::DATA_W-1:0]    pwdata,
  output logic [pmi_pkg::DATA_W-1:0]    prdata,
  output logic                          pready,
  // Input channel
  input  logic                          in_valid,
  output logic                          in_stall,
  input  pmi_pkg::sample_t              sample,
  input  pmi_pkg::sample_t              tap0,
  input  pmi_pkg::sample_t              tap1,
  input  pmi_pkg::sample_t              tap2,
  input  pmi_pkg::sample_t              tap3,
  input  pmi_pkg::sample_t              weight0,
  input  pmi_pkg::sample_t              weight1,
  input  pmi_pkg::sample_t              weight2,
  input  pmi_pkg::sample_t              weight3,
  input  logic                          last,
  // Output channel
  output logic                          out_valid,
  input  logic                          out_stall,
  output pmi_pkg::sample_t              result
);
  import pmi_pkg::*;

  // Configuration register
  mode_t interp_mode;

  // Pipeline control
  logic advance;
  logic prod_valid;
  logic fin_valid;
  logic term_valid;

  // Stage 1: tap products
  prod_t   prod [4];
  sample_t w1   [4];
  logic    last1;

  // Stage 2: accumulators and window snapshot
  acc_t    acc     [4];
  acc_t    acc_sum [4];
  acc_t    fin     [4];
  sample_t w2      [4];

  // Stage 3: weighted terms
  diff_t diff;
  term_t fin_ext  [4];
  term_t term     [4];
  term_t term_next[4];

  // Stage 4: combination, rounding and saturation
  sum_t    total;
  sum_t    shifted;
  sample_t result_next;

  // The pipeline moves unless a finished result is held by the consumer.
  assign advance  = !(out_valid && out_stall);
  assign in_stall = !advance;

  // Register port: writes land on the access cycle, reads are combinational.
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      interp_mode <= MODE_FULL;
    end else if (psel && penable && pwrite && pready &&
                 paddr[ADDR_W-1:2] == REG_INTERP_MODE) begin
      interp_mode <= pwdata[1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[ADDR_W-1:2] == REG_INTERP_MODE) begin
      prdata = DATA_W'(interp_mode);
    end
  end

  // Stage 1: register the four sample-by-tap products and the weights.
  always_ff @(posedge clk) begin
    if (rst) begin
      prod_valid <= 1'b0;
    end else if (advance) begin
      prod_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      prod[0] <= prod_t'(sample) * prod_t'(tap0);
      prod[1] <= prod_t'(sample) * prod_t'(tap1);
      prod[2] <= prod_t'(sample) * prod_t'(tap2);
      prod[3] <= prod_t'(sample) * prod_t'(tap3);
      w1[0]   <= weight0;
      w1[1]   <= weight1;
      w1[2]   <= weight2;
      w1[3]   <= weight3;
      last1   <= last;
    end
  end

  // Stage 2: add the products into the wrapping accumulators. The last
  // transaction of a window hands the finished sums on and clears them.
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      acc_sum[k] = acc[k] + acc_t'(prod[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fin_valid <= 1'b0;
      for (int k = 0; k < 4; k++) begin
        acc[k] <= '0;
      end
    end else if (advance) begin
      fin_valid <= prod_valid && last1;
      if (prod_valid) begin
        for (int k = 0; k < 4; k++) begin
          acc[k] <= last1 ? '0 : acc_sum[k];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && prod_valid && last1) begin
      for (int k = 0; k < 4; k++) begin
        fin[k] <= acc_sum[k];
        w2[k]  <= w1[k];
      end
    end
  end

  // Stage 3: form the weighted terms for the selected mode.
  always_comb begin
    diff = diff_t'(fin[0]) - diff_t'(fin[1]);
    for (int k = 0; k < 4; k++) begin
      fin_ext[k]   = term_t'(fin[k]);
      term_next[k] = '0;
    end
    case (interp_mode)
      MODE_LINEAR: begin
        term_next[0] = term_t'(diff) * term_t'(w2[0]);
        term_next[1] = fin_ext[1] <<< FRAC;
      end
      MODE_CUBIC: begin
        for (int k = 0; k < 4; k++) begin
          term_next[k] = fin_ext[k] * term_t'(w2[k]);
        end
      end
      default: begin
        term_next[0] = fin_ext[0] <<< FRAC;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      term_valid <= 1'b0;
    end else if (advance) begin
      term_valid <= fin_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && fin_valid) begin
      for (int k = 0; k < 4; k++) begin
        term[k] <= term_next[k];
      end
    end
  end

  // Stage 4: sum the terms, round half up, drop the fraction and saturate.
  always_comb begin
    total   = sum_t'(term[0]) + sum_t'(term[1]) + sum_t'(term[2]) +
              sum_t'(term[3]) + ROUND_OFS;
    shifted = total >>> SHIFT;
    if (shifted > SAT_MAX) begin
      result_next = sample_t'(SAT_MAX);
    end else if (shifted < SAT_MIN) begin
      result_next = sample_t'(SAT_MIN);
    end else begin
      result_next = sample_t'(shifted);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= term_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && term_valid) begin
      result <= result_next;
    end
  end

  // Closing a window leaves all four accumulators cleared.
  a_acc_cleared: assert property (@(posedge clk) disable iff (rst)
    (advance && prod_valid && last1) |=>
      (acc[0] == '0 && acc[1] == '0 && acc[2] == '0 && acc[3] == '0))
    else $error("accumulators not cleared after the last transaction");

  // Only a transaction marked last reaches the weighting stage.
  a_fin_from_last: assert property (@(posedge clk) disable iff (rst)
    $rose(fin_valid) |-> $past(prod_valid && last1))
    else $error("window snapshot without a last transaction");

  // Full mode uses only the first term.
  a_full_terms: assert property (@(posedge clk) disable iff (rst)
    (advance && fin_valid && interp_mode == MODE_FULL) |=>
      (term[1] == '0 && term[2] == '0 && term[3] == '0))
    else $error("full mode left stray terms");

  // A result only appears after a weighted set of terms.
  a_out_from_terms: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(term_valid))
    else $error("result without weighted terms");

endmodule

FILE: dv/tb_polyphase_mac_interpolated.sv
// ----------------------------------------------------------------------------
// tb_polyphase_mac_interpolated: self-checking bench for the polyphase MAC
// Drives sample/tap/weight transactions with random gaps and output stalls.
// Runs every interpolation mode, including the spare code. A scoreboard
// predicts each rounded, saturated output point and checks it in order.
// ----------------------------------------------------------------------------
module tb_polyphase_mac_interpolated;
  import pmi_pkg::*;

  // Wide signed type that holds the exact Q.3F combination.
  typedef logic signed [127:0] wide_t;

  // One input transaction as seen on the ports.
  typedef struct packed {
    sample_t       smp;
    sample_t [3:0] taps;
    sample_t [3:0] wts;
    logic          fin;
  } mac_item_t;

  // The spare mode code, which the block treats as full.
  localparam mode_t MODE_SPARE = 2'd3;

  localparam int STALL_LIMIT  = 4000;
  localparam int DRAIN_CYCLES = 8;
  localparam int LONG_ITEMS   = 64;
  localparam int PHASE_ITEMS  = 190;
  localparam int NUM_PHASES   = 7;
  localparam int MAX_REPORTS  = 10;
  localparam int SAT_TOP      = (1 << FRAC) - 1;
  localparam int SAT_BOTTOM   = -(1 << FRAC);

  // Predicts output points and checks them in arrival order.
  class mac_point_scoreboard;
    acc_t    row_acc[4];
    mode_t   mode;
    sample_t expected_points[$];
    int      errors;

    function new();
      foreach (row_acc[k]) row_acc[k] = '0;
      mode   = MODE_FULL;
      errors = 0;
    endfunction

    // Accumulate one accepted transaction; close the window on last.
    function void accumulate_item(mac_item_t it);
      wide_t comb;
      for (int k = 0; k < 4; k++)
        row_acc[k] = row_acc[k] + acc_t'($signed(it.smp)) * acc_t'($signed(it.taps[k]));
      if (!it.fin) return;
      case (mode)
        MODE_LINEAR: begin
          comb = (wide_t'(row_acc[0]) - wide_t'(row_acc[1])) * wide_t'($signed(it.wts[0]))
                 + (wide_t'(row_acc[1]) <<< FRAC);
        end
        MODE_CUBIC: begin
          comb = '0;
          for (int k = 0; k < 4; k++)
            comb = comb + wide_t'(row_acc[k]) * wide_t'($signed(it.wts[k]));
        end
        default: begin
          comb = wide_t'(row_acc[0]) <<< FRAC;
        end
      endcase
      // Round half up, drop the fraction, then clamp to the sample range.
      comb = (comb + (wide_t'(1) <<< (SHIFT - 1))) >>> SHIFT;
      if (comb > wide_t'(SAT_TOP)) comb = wide_t'(SAT_TOP);
      else if (comb < wide_t'(SAT_BOTTOM)) comb = wide_t'(SAT_BOTTOM);
      expected_points.push_back(sample_t'(comb));
      foreach (row_acc[k]) row_acc[k] = '0;
    endfunction

    // Compare one accepted output point with the oldest prediction.
    function void check_point(sample_t got);
      sample_t want;
      if (expected_points.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("unexpected output point %0d with no window closed", got);
        return;
      end
      want = expected_points.pop_front();
      if (got !== want) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("output point mismatch: expected %0d, actual %0d", want, got);
      end
    endfunction
  endclass

  logic                clk;
  logic                rst;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [ADDR_W-1:0]   paddr;
  logic [DATA_W-1:0]   pwdata;
  logic [DATA_W-1:0]   prdata;
  logic                pready;
  logic                in_valid;
  logic                in_stall;
  sample_t             sample;
  sample_t             tap0;
  sample_t             tap1;
  sample_t             tap2;
  sample_t             tap3;
  sample_t             weight0;
  sample_t             weight1;
  sample_t             weight2;
  sample_t             weight3;
  logic                last;
  logic                out_valid;
  logic                out_stall;
  sample_t             result;

  mac_point_scoreboard sb = new();
  mac_item_t           seen_item;
  int                  reg_errors = 0;
  int                  idle_cycles = 0;

  polyphase_mac_interpolated dut (
    .clk      (clk),
    .rst      (rst),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sample   (sample),
    .tap0     (tap0),
    .tap1     (tap1),
    .tap2     (tap2),
    .tap3     (tap3),
    .weight0  (weight0),
    .weight1  (weight1),
    .weight2  (weight2),
    .weight3  (weight3),
    .last     (last),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .result   (result)
  );

  // Clock generation.
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Input and output monitors; they see the values from before the edge.
  always @(posedge clk) begin
    if (!rst && in_valid && !in_stall) begin
      seen_item.smp  = sample;
      seen_item.taps = {tap3, tap2, tap1, tap0};
      seen_item.wts  = {weight3, weight2, weight1, weight0};
      seen_item.fin  = last;
      sb.accumulate_item(seen_item);
    end
    if (!rst && out_valid && !out_stall)
      sb.check_point(result);
  end

  // Watchdog: ends the run after too many cycles with no transaction.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) || psel) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Gap length: mostly none or short, now and then long.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Receiver back-pressure: runs without stall alternate with stall bursts.
  initial begin
    int run_len;
    int stall_len;
    out_stall = 1'b0;
    forever begin
      run_len = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 80) : $urandom_range(0, 6);
      repeat (run_len) begin
        @(negedge clk);
        out_stall <= 1'b0;
      end
      stall_len = pick_gap();
      if (stall_len == 0) stall_len = 1;
      repeat (stall_len) begin
        @(negedge clk);
        out_stall <= 1'b1;
      end
    end
  end

  // Field values: full random, with extremes and small magnitudes mixed in.
  function automatic sample_t pick_value();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) begin
      case ($urandom_range(0, 4))
        0:       return sample_t'(SAT_BOTTOM);
        1:       return sample_t'(SAT_TOP);
        2:       return sample_t'(0);
        3:       return sample_t'(-1);
        default: return sample_t'(1);
      endcase
    end
    if (r < 3) return sample_t'(int'($urandom_range(0, 511)) - 256);
    return sample_t'($urandom);
  endfunction

  function automatic mac_item_t random_item(logic fin);
    mac_item_t it;
    it.smp = pick_value();
    for (int k = 0; k < 4; k++) begin
      it.taps[k] = pick_value();
      it.wts[k]  = pick_value();
    end
    it.fin = fin;
    return it;
  endfunction

  // Directed transaction with the same tap on all rows and the same weight.
  function automatic mac_item_t make_item(int smp, int tap, int wt, logic fin);
    mac_item_t it;
    it.smp  = sample_t'(smp);
    it.taps = {4{sample_t'(tap)}};
    it.wts  = {4{sample_t'(wt)}};
    it.fin  = fin;
    return it;
  endfunction

  // Present one transaction after a gap and hold it until accepted.
  task automatic send_item(input mac_item_t it, input int gap);
    repeat (gap) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid <= 1'b1;
    sample   <= it.smp;
    tap0     <= it.taps[0];
    tap1     <= it.taps[1];
    tap2     <= it.taps[2];
    tap3     <= it.taps[3];
    weight0  <= it.wts[0];
    weight1  <= it.wts[1];
    weight2  <= it.wts[2];
    weight3  <= it.wts[3];
    last     <= it.fin;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Stop sending and wait for every predicted point, then idle for the extra cycles asked for.
  task automatic drain(input int extra);
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.expected_points.size() != 0) @(posedge clk);
    repeat (extra) @(posedge clk);
  endtask

  // One register access: setup cycle, then access cycle until pready.
  task automatic reg_access(input logic wr, input logic [REG_IDX_W-1:0] idx,
                            input logic [DATA_W-1:0] wdata,
                            output logic [DATA_W-1:0] rdata);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= ADDR_W'({idx, 2'b00});
    pwdata  <= wdata;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    rdata = prdata;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Change the interpolation mode while idle and read it back.
  task automatic set_mode(input mode_t m);
    logic [DATA_W-1:0] rd;
    drain(DRAIN_CYCLES);
    reg_access(1'b1, REG_INTERP_MODE, DATA_W'(m), rd);
    sb.mode = m;
    reg_access(1'b0, REG_INTERP_MODE, '0, rd);
    if (mode_t'(rd) !== m) begin
      reg_errors++;
      $display("interp_mode readback: expected %0d, actual %0d", m, rd);
    end
  endtask

  // Extremes, rounding ties in both signs, and a two-transaction window.
  task automatic run_directed();
    send_item(make_item(SAT_BOTTOM, SAT_BOTTOM, SAT_BOTTOM, 1'b1), 0);
    send_item(make_item(SAT_TOP, SAT_BOTTOM, SAT_TOP, 1'b1), 0);
    send_item(make_item(1, 16384, 16384, 1'b1), 0);
    send_item(make_item(-1, 16384, 16384, 1'b1), 1);
    send_item(make_item(1, 8192, 16384, 1'b1), 0);
    send_item(make_item(-1, 8192, 16384, 1'b1), 2);
    send_item(make_item(SAT_TOP, SAT_TOP, SAT_BOTTOM, 1'b0), 0);
    send_item(make_item(SAT_BOTTOM, SAT_TOP, SAT_TOP, 1'b1), 0);
  endtask

  // A long window of full-scale products that drives the accumulators far
  // beyond the output range in both signs.
  task automatic run_long_window();
    mac_item_t it;
    for (int i = 0; i < LONG_ITEMS; i++) begin
      it      = random_item(1'b0);
      it.smp  = sample_t'(SAT_BOTTOM);
      it.taps = {sample_t'(SAT_TOP), pick_value(), sample_t'(SAT_TOP), sample_t'(SAT_BOTTOM)};
      send_item(it, 0);
    end
    send_item(random_item(1'b1), 0);
  endtask

  // Main sequence: reset, then one phase per mode setting.
  initial begin
    mode_t phase_modes[NUM_PHASES];
    int    sent;
    int    win_len;
    int    r;
    bit    quiet;
    bit    paused;
    phase_modes = '{MODE_FULL, MODE_LINEAR, MODE_CUBIC, MODE_SPARE,
                    MODE_CUBIC, MODE_FULL, MODE_LINEAR};
    rst      = 1'b1;
    psel     = 1'b0;
    penable  = 1'b0;
    pwrite   = 1'b0;
    paddr    = '0;
    pwdata   = '0;
    in_valid = 1'b0;
    sample   = '0;
    tap0     = '0;
    tap1     = '0;
    tap2     = '0;
    tap3     = '0;
    weight0  = '0;
    weight1  = '0;
    weight2  = '0;
    weight3  = '0;
    last     = 1'b0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      set_mode(phase_modes[ph]);
      if (ph < 3) run_directed();
      if (ph == 2) run_long_window();
      sent   = 0;
      paused = 1'b0;
      while (sent < PHASE_ITEMS) begin
        r = $urandom_range(0, 99);
        if (r < 75) win_len = $urandom_range(1, 6);
        else if (r < 95) win_len = $urandom_range(7, 24);
        else win_len = $urandom_range(25, 80);
        quiet = ($urandom_range(0, 3) == 0);
        for (int i = 0; i < win_len; i++)
          send_item(random_item(i == win_len - 1), quiet ? 0 : pick_gap());
        sent += win_len;
        // Halfway through, let the pipeline run dry before going on.
        if (!paused && sent >= PHASE_ITEMS / 2) begin
          drain(0);
          paused = 1'b1;
        end
      end
    end

    drain(DRAIN_CYCLES);
    if (sb.errors == 0 && reg_errors == 0 && sb.expected_points.size() == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule
